// File: design/swss_pkg.sv
`default_nettype none

package swss_pkg;

  // field widths of one input item and one result item
  localparam int unsigned OwnCountW   = 32;
  localparam int unsigned StagesBackW = 10;
  localparam int unsigned StageTotalW = 64;

  // stream data widths, padded to whole bytes
  localparam int unsigned InTdataW  = 48;
  localparam int unsigned OutTdataW = 64;

  // default depth of the prefix ring
  localparam int unsigned HistoryDepthDefault = 1024;

endpackage : swss_pkg

`default_nettype wire

// File: design/suffix_window_stage_sum.sv
// suffix_window_stage_sum
//
// Each input item is one stage: an own count plus the number k of preceding
// stage totals to add. The block returns own + sum of the last k totals
// (modulo 2^64) and records the new total in a ring of running prefix sums.
// Slave channel: s_axis_tdata = {stages_back, own_count}, s_axis_tuser =
// start_new, which clears the history before the stage is processed.
// Master channel: m_axis_tdata = stage_total, m_axis_tuser = range_error,
// raised (with a zero total) when k exceeds the stages in the window; such
// a stage is not recorded.
// Throughput: one item per cycle while the receiver does not stall. The
// result passes through the ring read, the difference stage, then the prefix
// accumulate that also writes the ring and fills the output register. A ring
// slot written at the accepting edge, by the item two places ahead, is
// forwarded.
// Reset clears the window and running prefix; the ring needs no clearing.
// When the receiver stalls the whole pipeline holds and s_axis_tready drops
// while the output register is full and not taken.
`default_nettype none

module suffix_window_stage_sum
  import swss_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HistoryDepthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // slave side
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InTdataW-1:0]  s_axis_tdata,  // own_count[31:0], stages_back[41:32]
  input  wire logic                 s_axis_tuser,  // start_new
  // master side
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutTdataW-1:0]      m_axis_tdata,  // stage_total[63:0]
  output logic                      m_axis_tuser   // range_error
);

  localparam int unsigned AW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CMPW = ((AW > StagesBackW) ? AW : StagesBackW) + 1;

  // input fields
  logic [OwnCountW-1:0]   own_count;
  logic [StagesBackW-1:0] stages_back;
  logic                   start_new;

  assign own_count   = s_axis_tdata[OwnCountW-1:0];
  assign stages_back = s_axis_tdata[OwnCountW+StagesBackW-1:OwnCountW];
  assign start_new   = s_axis_tuser;

  // pipeline advance
  logic en;
  logic accept;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  // window control registers
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          base_zero_q, base_zero_d;

  // accept-side decode
  logic [AW-1:0]   wp_c, cnt_c, wp_next;
  logic            bz_c;
  logic [CMPW-1:0] wp_ext, k_ext, cnt_ext, older_w;
  logic [AW-1:0]   older;
  logic            err_c, zero_c, base_c, hit_c;

  // stage 1: ring read data present
  logic                   s1_valid_q;
  logic [OwnCountW-1:0]   s1_own_q;
  logic                   s1_err_q, s1_start_q, s1_zero_q, s1_base_q, s1_hit_q;
  logic [AW-1:0]          s1_waddr_q;
  logic [StageTotalW-1:0] rd_q;
  logic [StageTotalW-1:0] fwd_q;

  // stage 2: difference ready
  logic                   s2_valid_q;
  logic [StageTotalW-1:0] s2_diff_q;
  logic                   s2_err_q, s2_start_q, s2_zero_q;
  logic [AW-1:0]          s2_waddr_q;

  logic [StageTotalW-1:0] rp_q;
  logic [StageTotalW-1:0] ring [HISTORY_DEPTH];

  // history clear applies before the stage
  always_comb begin
    wp_c    = start_new ? '0 : wp_q;
    cnt_c   = start_new ? '0 : cnt_q;
    bz_c    = start_new ? 1'b1 : base_zero_q;
    wp_ext  = CMPW'(wp_c);
    k_ext   = CMPW'(stages_back);
    cnt_ext = CMPW'(cnt_c);
    err_c   = k_ext > cnt_ext;
    if (wp_ext >= k_ext) begin
      older_w = wp_ext - k_ext;
    end else begin
      older_w = wp_ext + CMPW'(HISTORY_DEPTH) - k_ext;
    end
    older   = older_w[AW-1:0];
    zero_c  = (stages_back == '0);
    base_c  = !zero_c && bz_c && (older == '0);
    // slot being written at this edge by the item in stage 2
    hit_c   = s2_valid_q && !s2_err_q && (s2_waddr_q == older);
    wp_next = (wp_c == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_c + AW'(1);

    wp_d        = wp_q;
    cnt_d       = cnt_q;
    base_zero_d = base_zero_q;
    if (accept) begin
      if (err_c) begin
        wp_d        = wp_c;
        cnt_d       = cnt_c;
        base_zero_d = bz_c;
      end else begin
        wp_d        = wp_next;
        cnt_d       = (cnt_c < AW'(HISTORY_DEPTH - 1)) ? cnt_c + AW'(1) : cnt_c;
        base_zero_d = (wp_next == '0) ? 1'b0 : bz_c;
      end
    end
  end

  // window control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      cnt_q       <= '0;
      base_zero_q <= 1'b1;
    end else begin
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      base_zero_q <= base_zero_d;
    end
  end

  // stage 2 arithmetic on forwarded read data
  logic [StageTotalW-1:0] rd_use, diff_d;

  always_comb begin
    rd_use = s1_hit_q ? fwd_q : rd_q;
    diff_d = StageTotalW'(s1_own_q) - ((s1_zero_q || s1_base_q) ? '0 : rd_use);
  end

  // prefix accumulate
  logic [StageTotalW-1:0] rp_base, total_c, rp_next;
  logic                   rec_c;

  always_comb begin
    rp_base = s2_start_q ? '0 : rp_q;
    total_c = (s2_zero_q ? '0 : rp_base) + s2_diff_q;
    rp_next = rp_base + (s2_zero_q ? '0 : rp_base) + s2_diff_q;
    rec_c   = en && s2_valid_q && !s2_err_q;
  end

  // ring memory: read at accept, write from stage 2
  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_q <= ring[older];
    end
    if (rec_c) begin
      ring[s2_waddr_q] <= rp_next;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_own_q   <= own_count;
      s1_err_q   <= err_c;
      s1_start_q <= start_new;
      s1_zero_q  <= zero_c;
      s1_base_q  <= base_c;
      s1_hit_q   <= hit_c;
      s1_waddr_q <= wp_next;
      s2_diff_q  <= diff_d;
      s2_err_q   <= s1_err_q;
      s2_start_q <= s1_start_q;
      s2_zero_q  <= s1_zero_q;
      s2_waddr_q <= s1_waddr_q;
    end
    if (rec_c) begin
      fwd_q <= rp_next;
    end
    if (en && s2_valid_q) begin
      m_axis_tdata <= s2_err_q ? '0 : total_c;
      m_axis_tuser <= s2_err_q;
    end
  end

  // valid bits and running prefix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      rp_q          <= '0;
    end else if (en) begin
      s1_valid_q    <= accept;
      s2_valid_q    <= s1_valid_q;
      m_axis_tvalid <= s2_valid_q;
      if (s2_valid_q) begin
        rp_q <= s2_err_q ? rp_base : rp_next;
      end
    end
  end

endmodule : suffix_window_stage_sum

`default_nettype wire
